// ----- src/mas_pkg.sv -----
package mas_pkg;

    localparam int WINDOW     = 10;
    localparam int CHANNELS   = 6;
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 24;
    localparam int AVG_W      = 20;
    localparam int PHYS_W     = 28;
    localparam int FRAC_SHIFT = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int STAGES     = 6;

    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
    localparam int MAG_W  = SUM_W + 4;
    localparam int PROD_W = AVG_W + GAIN_W + 1;
    localparam int SH_W   = PROD_W - FRAC_SHIFT;

    localparam logic [MAG_W-1:0] RECIP = MAG_W'((64'd1 << MAG_W) / WINDOW);
    localparam logic [MAG_W-1:0] WIN_K = MAG_W'(WINDOW);

    localparam logic [GAIN_W-1:0] ACCEL_GAIN_RST = 24'd250216;
    localparam logic [GAIN_W-1:0] GYRO_GAIN_RST  = 24'd64000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACCEL_GAIN = 2'd0,
        CFG_GYRO_GAIN  = 2'd1
    } t_cfg_idx;

    typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] t_chan_vec;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] accel_y;
        logic signed [SAMPLE_W-1:0] accel_z;
        logic signed [SAMPLE_W-1:0] rate_x;
        logic signed [SAMPLE_W-1:0] rate_y;
        logic signed [SAMPLE_W-1:0] rate_z;
    } t_in;

    typedef struct packed {
        logic signed [AVG_W-1:0]  accel_avg_x;
        logic signed [AVG_W-1:0]  accel_avg_y;
        logic signed [AVG_W-1:0]  accel_avg_z;
        logic signed [AVG_W-1:0]  rate_avg_x;
        logic signed [AVG_W-1:0]  rate_avg_y;
        logic signed [AVG_W-1:0]  rate_avg_z;
        logic signed [PHYS_W-1:0] accel_phys_x;
        logic signed [PHYS_W-1:0] accel_phys_y;
        logic signed [PHYS_W-1:0] accel_phys_z;
        logic signed [PHYS_W-1:0] rate_phys_x;
        logic signed [PHYS_W-1:0] rate_phys_y;
        logic signed [PHYS_W-1:0] rate_phys_z;
    } t_out;

    typedef struct packed {
        logic mag;
        logic prod;
        logic avg;
        logic scl;
        logic outp;
    } t_lane_en;

endpackage

// ----- src/mas_cell.sv -----
module mas_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_shift,
    input  mas_pkg::t_chan_vec i_data,
    output mas_pkg::t_chan_vec o_data
);

    mas_pkg::t_chan_vec r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule

// ----- src/mas_lane.sv -----
module mas_lane (
    input  logic                                 i_clk,
    input  mas_pkg::t_lane_en                    i_en,
    input  logic signed [mas_pkg::SUM_W-1:0]     i_sum,
    input  logic [mas_pkg::GAIN_W-1:0]           i_gain,
    output logic signed [mas_pkg::AVG_W-1:0]     o_avg,
    output logic signed [mas_pkg::PHYS_W-1:0]    o_phys
);

    localparam int MW = mas_pkg::MAG_W;
    localparam int PW = mas_pkg::PHYS_W;

    logic [MW-1:0]   w_ext;
    logic [MW-1:0]   n_mag;
    logic [MW-1:0]   r_mag;
    logic            r_neg;
    logic [2*MW-1:0] r_prod;
    logic [MW-1:0]   r_mag2;
    logic            r_neg2;
    logic [MW-1:0]   w_q0;
    logic [MW-1:0]   w_rem;
    logic [MW-1:0]   w_q;
    logic [MW-1:0]   w_qs;
    logic signed [mas_pkg::AVG_W-1:0]  r_avg;
    logic signed [mas_pkg::AVG_W-1:0]  r_avg2;
    logic signed [mas_pkg::AVG_W-1:0]  r_avg3;
    logic signed [mas_pkg::PROD_W-1:0] r_mul;
    logic [mas_pkg::SH_W-1:0]          w_sh;
    logic [mas_pkg::SH_W-PW:0]         w_hi;
    logic signed [PW-1:0]              n_phys;
    logic signed [PW-1:0]              r_phys;

    always_comb begin
        w_ext = {i_sum, 4'b0000};
        n_mag = w_ext[MW-1] ? (~w_ext + MW'(1)) : w_ext;

        w_q0  = r_prod[2*MW-1:MW];
        w_rem = r_mag2 - MW'(w_q0 * mas_pkg::WIN_K);
        w_q   = (w_rem >= mas_pkg::WIN_K) ? (w_q0 + MW'(1)) : w_q0;
        w_qs  = r_neg2 ? (~w_q + MW'(1)) : w_q;

        w_sh = r_mul[mas_pkg::PROD_W-1:mas_pkg::FRAC_SHIFT];
        w_hi = w_sh[mas_pkg::SH_W-1:PW-1];
        if ((&w_hi) || !(|w_hi)) begin
            n_phys = w_sh[PW-1:0];
        end else if (w_sh[mas_pkg::SH_W-1]) begin
            n_phys = {1'b1, {(PW-1){1'b0}}};
        end else begin
            n_phys = {1'b0, {(PW-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.mag) begin
            r_mag <= n_mag;
            r_neg <= w_ext[MW-1];
        end
        if (i_en.prod) begin
            r_prod <= r_mag * mas_pkg::RECIP;
            r_mag2 <= r_mag;
            r_neg2 <= r_neg;
        end
        if (i_en.avg) begin
            r_avg <= w_qs[mas_pkg::AVG_W-1:0];
        end
        if (i_en.scl) begin
            r_mul  <= r_avg * $signed({1'b0, i_gain});
            r_avg2 <= r_avg;
        end
        if (i_en.outp) begin
            r_phys <= n_phys;
            r_avg3 <= r_avg2;
        end
    end

    assign o_avg  = r_avg3;
    assign o_phys = r_phys;

endmodule

// ----- src/six_axis_moving_average_scaler.sv -----
// Each accepted beat carries one six-axis sample. It is shifted into a chain of cells holding
// the last ten samples (all zero after reset) while running sums per channel are updated, and
// the matching beat out carries every channel's window average in Q.4, truncated toward
// zero, and that average times the accelerometer or gyro gain, in Q.4, floored and saturated.
// A new sample can be taken every cycle unless the output stalls. The six-stage pipeline is sum,
// magnitude, reciprocal multiply, quotient correction, gain multiply and saturation. The user
// must write gains through the configuration port while no beat is in flight; it is unchecked.
module six_axis_moving_average_scaler (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  mas_pkg::t_in                         i_data,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output mas_pkg::t_out                        o_data,
    input  logic                                 i_cfg_we,
    input  logic [mas_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [mas_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int W  = mas_pkg::WINDOW;
    localparam int C  = mas_pkg::CHANNELS;
    localparam int SW = mas_pkg::SUM_W;
    localparam int DW = mas_pkg::SAMPLE_W;
    localparam int NS = mas_pkg::STAGES;

    mas_pkg::t_chan_vec w_chain [W+1];
    mas_pkg::t_chan_vec w_new;
    mas_pkg::t_chan_vec w_old;

    logic [NS-1:0] r_v;
    logic [NS-1:0] w_rdy;
    logic          w_acc;

    logic signed [SW-1:0] r_sum [C];
    logic signed [SW-1:0] n_sum [C];

    logic [mas_pkg::GAIN_W-1:0] r_accel_gain;
    logic [mas_pkg::GAIN_W-1:0] r_gyro_gain;

    mas_pkg::t_lane_en w_en;

    logic signed [mas_pkg::AVG_W-1:0]  w_avg  [C];
    logic signed [mas_pkg::PHYS_W-1:0] w_phys [C];

    assign w_new      = mas_pkg::t_chan_vec'(i_data);
    assign w_chain[0] = w_new;
    assign w_old      = w_chain[W];

    always_comb begin
        w_rdy[NS-1] = !r_v[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
        w_acc = i_valid && w_rdy[0];

        for (int c = 0; c < C; c++) begin
            n_sum[c] = r_sum[c]
                + {{(SW-DW){w_new[C-1-c][DW-1]}}, w_new[C-1-c]}
                - {{(SW-DW){w_old[C-1-c][DW-1]}}, w_old[C-1-c]};
        end

        w_en.mag  = w_rdy[1];
        w_en.prod = w_rdy[2];
        w_en.avg  = w_rdy[3];
        w_en.scl  = w_rdy[4];
        w_en.outp = w_rdy[5];
    end

    genvar g;
    generate
        for (g = 0; g < W; g++) begin : g_cell
            mas_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_acc),
                .i_data  (w_chain[g]),
                .o_data  (w_chain[g+1])
            );
        end

        for (g = 0; g < C; g++) begin : g_lane
            mas_lane u_lane (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_sum  (r_sum[g]),
                .i_gain ((g < 3) ? r_accel_gain : r_gyro_gain),
                .o_avg  (w_avg[g]),
                .o_phys (w_phys[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
            for (int c = 0; c < C; c++) begin
                r_sum[c] <= '0;
            end
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= w_acc;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (w_acc) begin
                for (int c = 0; c < C; c++) begin
                    r_sum[c] <= n_sum[c];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_gain <= mas_pkg::ACCEL_GAIN_RST;
            r_gyro_gain  <= mas_pkg::GYRO_GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (mas_pkg::t_cfg_idx'(i_cfg_idx))
                mas_pkg::CFG_ACCEL_GAIN: r_accel_gain <= i_cfg_data[mas_pkg::GAIN_W-1:0];
                mas_pkg::CFG_GYRO_GAIN:  r_gyro_gain  <= i_cfg_data[mas_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_stall = !w_rdy[0];

    assign o_data.accel_avg_x  = w_avg[0];
    assign o_data.accel_avg_y  = w_avg[1];
    assign o_data.accel_avg_z  = w_avg[2];
    assign o_data.rate_avg_x   = w_avg[3];
    assign o_data.rate_avg_y   = w_avg[4];
    assign o_data.rate_avg_z   = w_avg[5];
    assign o_data.accel_phys_x = w_phys[0];
    assign o_data.accel_phys_y = w_phys[1];
    assign o_data.accel_phys_z = w_phys[2];
    assign o_data.rate_phys_x  = w_phys[3];
    assign o_data.rate_phys_y  = w_phys[4];
    assign o_data.rate_phys_z  = w_phys[5];

endmodule

// ----- tb/mas_beat_checker.sv -----
module mas_beat_checker
    import mas_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in                   i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out                  i_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked
);

    localparam int NUM_FIELDS = 2 * CHANNELS;
    localparam longint PHYS_HI = (64'sd1 <<< (PHYS_W - 1)) - 1;
    localparam longint PHYS_LO = -(64'sd1 <<< (PHYS_W - 1));

    string field_names [NUM_FIELDS] = '{
        "accel_avg_x", "accel_avg_y", "accel_avg_z",
        "rate_avg_x", "rate_avg_y", "rate_avg_z",
        "accel_phys_x", "accel_phys_y", "accel_phys_z",
        "rate_phys_x", "rate_phys_y", "rate_phys_z"
    };

    logic signed [SAMPLE_W-1:0] window_ring [WINDOW][CHANNELS];
    int unsigned                next_slot;
    logic [GAIN_W-1:0]          accel_gain_q;
    logic [GAIN_W-1:0]          gyro_gain_q;
    t_out                       awaited_averages [$];
    int                         fails = 0;
    int                         checked = 0;

    // Writes the sample into the ring, then averages every channel and scales it.
    function automatic t_out advance_window(input t_in s);
        t_out                       r;
        logic signed [SAMPLE_W-1:0] smp [CHANNELS];
        int                         sum;
        int                         avg_v [CHANNELS];
        longint                     phys_v [CHANNELS];
        longint                     prod;
        logic [GAIN_W-1:0]          gain;
        smp[0] = s.accel_x;
        smp[1] = s.accel_y;
        smp[2] = s.accel_z;
        smp[3] = s.rate_x;
        smp[4] = s.rate_y;
        smp[5] = s.rate_z;
        for (int c = 0; c < CHANNELS; c++) window_ring[next_slot][c] = smp[c];
        next_slot = (next_slot + 1 >= WINDOW) ? 0 : next_slot + 1;
        for (int c = 0; c < CHANNELS; c++) begin
            sum = 0;
            for (int k = 0; k < WINDOW; k++) sum += int'(window_ring[k][c]);
            avg_v[c] = (sum * 16) / WINDOW;
            gain = (c < 3) ? accel_gain_q : gyro_gain_q;
            prod = longint'(avg_v[c]) * longint'(gain);
            phys_v[c] = prod >>> FRAC_SHIFT;
            if (phys_v[c] > PHYS_HI) phys_v[c] = PHYS_HI;
            if (phys_v[c] < PHYS_LO) phys_v[c] = PHYS_LO;
        end
        r.accel_avg_x  = AVG_W'(avg_v[0]);
        r.accel_avg_y  = AVG_W'(avg_v[1]);
        r.accel_avg_z  = AVG_W'(avg_v[2]);
        r.rate_avg_x   = AVG_W'(avg_v[3]);
        r.rate_avg_y   = AVG_W'(avg_v[4]);
        r.rate_avg_z   = AVG_W'(avg_v[5]);
        r.accel_phys_x = PHYS_W'(phys_v[0]);
        r.accel_phys_y = PHYS_W'(phys_v[1]);
        r.accel_phys_z = PHYS_W'(phys_v[2]);
        r.rate_phys_x  = PHYS_W'(phys_v[3]);
        r.rate_phys_y  = PHYS_W'(phys_v[4]);
        r.rate_phys_z  = PHYS_W'(phys_v[5]);
        return r;
    endfunction

    function automatic logic signed [63:0] result_field(input t_out r, input int f);
        case (f)
            0:       return r.accel_avg_x;
            1:       return r.accel_avg_y;
            2:       return r.accel_avg_z;
            3:       return r.rate_avg_x;
            4:       return r.rate_avg_y;
            5:       return r.rate_avg_z;
            6:       return r.accel_phys_x;
            7:       return r.accel_phys_y;
            8:       return r.accel_phys_z;
            9:       return r.rate_phys_x;
            10:      return r.rate_phys_y;
            default: return r.rate_phys_z;
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        t_out want;
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW; k++) begin
                for (int c = 0; c < CHANNELS; c++) window_ring[k][c] = '0;
            end
            next_slot    = 0;
            accel_gain_q = ACCEL_GAIN_RST;
            gyro_gain_q  = GYRO_GAIN_RST;
            awaited_averages.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ACCEL_GAIN: accel_gain_q = i_cfg_data[GAIN_W-1:0];
                    CFG_GYRO_GAIN:  gyro_gain_q  = i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (awaited_averages.size() == 0) begin
                    if (fails < 10) begin
                        $display("Result beat arrived with nothing expected: %h", i_out_data);
                    end
                    fails++;
                end else begin
                    want = awaited_averages.pop_front();
                    checked++;
                    for (int f = 0; f < NUM_FIELDS; f++) begin
                        if (result_field(want, f) !== result_field(i_out_data, f)) begin
                            if (fails < 10) begin
                                $display("Result %0d, %s: expected %0d, got %0d", checked,
                                         field_names[f], result_field(want, f),
                                         result_field(i_out_data, f));
                            end
                            fails++;
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                awaited_averages.push_back(advance_window(i_in_data));
            end
        end
        o_fail_count <= fails;
        o_pending    <= awaited_averages.size();
        o_checked    <= checked;
    end

endmodule

// ----- tb/tb_six_axis_moving_average_scaler.sv -----
module tb_six_axis_moving_average_scaler;
    import mas_pkg::*;

    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 238;
    localparam int HOLD_CYCLES     = 80;
    localparam int HOLD_AT_ITEM    = 100;
    localparam int unsigned LIMIT  = 200000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_valid    = 1'b0;
    logic                  o_stall;
    t_in                   i_data     = '0;
    logic                  o_valid;
    logic                  i_stall    = 1'b0;
    t_out                  o_data;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int          fail_count;
    int          pending;
    int          checked;
    int          sent_count    = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          hold_seq      = 0;
    int unsigned cycle_count   = 0;

    six_axis_moving_average_scaler dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    mas_beat_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_data   (o_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // The receiver stalls at random, or for a long hold-off whenever one is requested.
    initial begin : receiver
        int hold_left;
        int seen;
        hold_left = 0;
        seen      = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_stall   <= 1'b1;
                hold_left = hold_left - 1;
            end else if (hold_seq != seen) begin
                seen      = hold_seq;
                hold_left = HOLD_CYCLES - 1;
                i_stall   <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    function automatic t_in uniform_sample(input logic [SAMPLE_W-1:0] v);
        return t_in'({v, v, v, v, v, v});
    endfunction

    function automatic t_in random_sample();
        logic [SAMPLE_W-1:0] v [CHANNELS];
        int                  mode;
        mode = $urandom_range(7);
        for (int c = 0; c < CHANNELS; c++) begin
            case (mode)
                0:       v[c] = 16'h7FFF;
                1:       v[c] = 16'h8000;
                2:       v[c] = SAMPLE_W'($urandom_range(16)) - 16'd8;
                default: v[c] = SAMPLE_W'($urandom);
            endcase
        end
        return t_in'({v[0], v[1], v[2], v[3], v[4], v[5]});
    endfunction

    // Valid stays high after a beat is taken; the next call decides whether to drop it.
    task automatic offer_sample(input t_in s);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (STAGES + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [GAIN_W-1:0] accel_set [PHASES];
        logic [GAIN_W-1:0] gyro_set [PHASES];
        int                send_pct [PHASES];
        int                rx_pct [PHASES];
        accel_set = '{ACCEL_GAIN_RST, 24'd0, 24'hFFFFFF, 24'($urandom), 24'($urandom), 24'd1};
        gyro_set  = '{GYRO_GAIN_RST, 24'd0, 24'hFFFFFF, 24'($urandom), 24'($urandom),
                      24'hFFFFFF};
        send_pct  = '{0, 78, 0, 29, 78, 0};
        rx_pct    = '{0, 0, 78, 29, 0, 78};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The first results average the sample against a ring that is still zero.
        offer_sample(t_in'({16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h7FFF}));
        offer_sample(t_in'({16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h8000, 16'h0001}));
        offer_sample(uniform_sample(16'h0001));
        settle();

        // Full gains, then writes to unused indexes that must leave them alone.
        write_reg(CFG_ACCEL_GAIN, 24'hFFFFFF);
        write_reg(CFG_GYRO_GAIN, 24'hFFFFFF);
        write_reg(CFG_SPARE_A, 24'h000001);
        write_reg(CFG_SPARE_B, 24'h000000);
        repeat (WINDOW) offer_sample(uniform_sample(16'h8000));
        repeat (WINDOW) offer_sample(uniform_sample(16'h7FFF));
        settle();

        for (int p = 0; p < PHASES; p++) begin
            write_reg(CFG_ACCEL_GAIN, accel_set[p]);
            write_reg(CFG_GYRO_GAIN, gyro_set[p]);
            send_idle_pct = send_pct[p];
            stall_pct     <= rx_pct[p];
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (p == 0 && i == HOLD_AT_ITEM) hold_seq <= hold_seq + 1;
                offer_sample(random_sample());
            end
            settle();
        end

        $display("Summary: %0d samples sent over %0d gain and flow-control phases.",
                 sent_count, PHASES + 2);
        $display("Summary: %0d result beats compared field by field.", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/mas_pkg.sv
src/mas_cell.sv
src/mas_lane.sv
src/six_axis_moving_average_scaler.sv
tb/mas_beat_checker.sv
tb/tb_six_axis_moving_average_scaler.sv
